// ===== hw/rtl/ril_pkg.sv =====
`default_nettype none
package ril_pkg;

    localparam int QB   = 16;   // fraction bits of Q16.16
    localparam int DW   = 32;   // coordinate width
    localparam int LW   = 31;   // length and parameter width
    localparam int PW   = 64;   // full product width
    localparam int FW   = PW - QB;  // floored product width
    localparam int DOTW = FW + 1;   // dot product width
    localparam int NUMW = DOTW + 1; // numerator width
    localparam int AW   = NUMW - 1; // numerator magnitude width
    localparam int BW   = DOTW - 1; // denominator magnitude width
    localparam int QW   = LW;       // quotient bits produced
    localparam int RW   = BW;       // partial remainder width
    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_NORMAL_X     = 2'd0,
        REG_NORMAL_Y     = 2'd1,
        REG_PLANE_OFFSET = 2'd2
    } reg_idx_t;

    localparam logic signed [DW-1:0] NORMAL_X_RST     = 32'sh0001_0000;
    localparam logic signed [DW-1:0] NORMAL_Y_RST     = 32'sh0000_0000;
    localparam logic signed [DW-1:0] PLANE_OFFSET_RST = 32'sh0000_0000;

    typedef struct packed {
        logic signed [DW-1:0] start_x;
        logic signed [DW-1:0] start_y;
        logic signed [DW-1:0] dir_x;
        logic signed [DW-1:0] dir_y;
        logic        [LW-1:0] ray_length;
    } in_t;

    typedef struct packed {
        logic                 hit;
        logic        [LW-1:0] hit_distance;
        logic signed [DW-1:0] hit_x;
        logic signed [DW-1:0] hit_y;
        logic signed [DW-1:0] start_distance;
        logic                 start_in_front;
        logic                 ray_inward;
    } out_t;

    typedef struct packed {
        in_t                  ray;
        logic signed [PW-1:0] p_sx;
        logic signed [PW-1:0] p_sy;
        logic signed [PW-1:0] p_dx;
        logic signed [PW-1:0] p_dy;
    } prod_t;

    typedef struct packed {
        in_t                    ray;
        logic signed [DOTW-1:0] ds;
        logic signed [DOTW-1:0] dd;
        logic signed [NUMW-1:0] num;
    } dot_t;

    typedef struct packed {
        in_t                  ray;
        logic        [RW-1:0] rem;
        logic        [BW-1:0] dvs;
        logic        [QW-1:0] dlo;
        logic        [QW-1:0] q;
        logic                 pass;
        logic signed [DW-1:0] sdist;
        logic                 front;
        logic                 inward;
    } div_t;

    typedef struct packed {
        logic signed [DW-1:0] sx;
        logic signed [DW-1:0] sy;
        logic        [QW-1:0] q;
        logic                 pass;
        logic signed [PW-1:0] mx;
        logic signed [PW-1:0] my;
        logic signed [DW-1:0] sdist;
        logic                 front;
        logic                 inward;
    } mul_t;

    // One restoring division step: brings down the next dividend bit.
    function automatic div_t div_step(input div_t d);
        logic [RW:0] trial;
        div_t        r;
        r     = d;
        trial = {d.rem, d.dlo[QW-1]};
        r.dlo = {d.dlo[QW-2:0], 1'b0};
        if (trial >= {1'b0, d.dvs}) begin
            r.rem = RW'(trial - {1'b0, d.dvs});
            r.q   = {d.q[QW-2:0], 1'b1};
        end else begin
            r.rem = trial[RW-1:0];
            r.q   = {d.q[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] sat_q(input logic signed [NUMW-1:0] v);
        logic signed [DW-1:0] r;
        if ((&v[NUMW-1:DW-1]) || !(|v[NUMW-1:DW-1])) begin
            r = v[DW-1:0];
        end else if (v[NUMW-1]) begin
            r = {1'b1, {(DW-1){1'b0}}};
        end else begin
            r = {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ray_line_intersection_2d.sv =====
// Channel  Direction  Handshake          Beat
// s_       in         s_valid/s_ready    ril_pkg::in_t  (one ray)
// m_       out        m_valid/m_ready    ril_pkg::out_t (one result)
// cfg      in         APB psel/penable   32-bit register write or read
//
// One ray per cycle enters while s_ready is high; each result leaves after its ray
// has passed the 31-stage bit-per-stage divider for t, plus the
// multiply, dot product, setup, hit-point multiply and output stages.
// aresetn (synchronous) clears all valid bits and loads the line registers.
// Any stage with a bubble moves on while a later stage is stalled.
`default_nettype none
module ray_line_intersection_2d (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire ril_pkg::in_t          s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ril_pkg::out_t              m_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ril_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ril_pkg::*;

    localparam int NS = QW + 5;

    logic signed [DW-1:0] normal_x_reg, normal_y_reg, plane_offset_reg;
    reg_idx_t             widx;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_x_reg     <= NORMAL_X_RST;
            normal_y_reg     <= NORMAL_Y_RST;
            plane_offset_reg <= PLANE_OFFSET_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (widx)
                REG_NORMAL_X:     normal_x_reg     <= pwdata;
                REG_NORMAL_Y:     normal_y_reg     <= pwdata;
                REG_PLANE_OFFSET: plane_offset_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_NORMAL_X:     prdata = normal_x_reg;
            REG_NORMAL_Y:     prdata = normal_y_reg;
            REG_PLANE_OFFSET: prdata = plane_offset_reg;
            default:          prdata = '0;
        endcase
    end

    // Stage layout: 0 products, 1 dot products, 2 divider setup,
    // 3..QW+2 divider, QW+3 hit-point products, QW+4 output.
    logic [NS-1:0] v_reg;
    logic [NS:0]   adv;

    always_comb begin
        adv[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= (k == 0) ? s_valid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    prod_t prod_reg, prod_next;
    dot_t  dot_reg, dot_next;
    div_t  div_reg [0:QW];
    div_t  prep_next;
    mul_t  mul_reg, mul_next;
    out_t  out_reg, out_next;

    always_comb begin
        prod_next.ray  = s_data;
        prod_next.p_sx = s_data.start_x * normal_x_reg;
        prod_next.p_sy = s_data.start_y * normal_y_reg;
        prod_next.p_dx = s_data.dir_x * normal_x_reg;
        prod_next.p_dy = s_data.dir_y * normal_y_reg;
    end

    // Taking the upper bits of a product floors it toward minus infinity.
    always_comb begin
        dot_next.ray = prod_reg.ray;
        dot_next.ds  = {prod_reg.p_sx[PW-1], prod_reg.p_sx[PW-1:QB]}
                     + {prod_reg.p_sy[PW-1], prod_reg.p_sy[PW-1:QB]};
        dot_next.dd  = {prod_reg.p_dx[PW-1], prod_reg.p_dx[PW-1:QB]}
                     + {prod_reg.p_dy[PW-1], prod_reg.p_dy[PW-1:QB]};
        dot_next.num = {{(NUMW-DW){plane_offset_reg[DW-1]}}, plane_offset_reg}
                     - {dot_next.ds[DOTW-1], dot_next.ds};
    end

    logic signed [NUMW-1:0] num_neg, dd_neg, sd_full;
    logic        [AW-1:0]   mag_a;
    logic        [BW-1:0]   mag_b;
    logic                   ovf, neg;

    always_comb begin
        num_neg = -dot_reg.num;
        dd_neg  = -{dot_reg.dd[DOTW-1], dot_reg.dd};
        mag_a   = dot_reg.num[NUMW-1] ? num_neg[AW-1:0] : dot_reg.num[AW-1:0];
        mag_b   = dot_reg.dd[DOTW-1] ? dd_neg[BW-1:0] : dot_reg.dd[BW-1:0];
        // The quotient fits in QW bits exactly when A < B * 2^(QW-QB).
        ovf     = {{(BW+QW-QB-AW){1'b0}}, mag_a} >= {mag_b, {(QW-QB){1'b0}}};
        neg     = (dot_reg.num != '0) && (dot_reg.num[NUMW-1] != dot_reg.dd[DOTW-1]);
        sd_full = {dot_reg.ds[DOTW-1], dot_reg.ds}
                - {{(NUMW-DW){plane_offset_reg[DW-1]}}, plane_offset_reg};

        prep_next.ray    = dot_reg.ray;
        prep_next.rem    = {{(RW-(AW-(QW-QB))){1'b0}}, mag_a[AW-1:QW-QB]};
        prep_next.dvs    = mag_b;
        prep_next.dlo    = {mag_a[QW-QB-1:0], {QB{1'b0}}};
        prep_next.q      = '0;
        prep_next.pass   = (dot_reg.dd != '0) && !neg && !ovf;
        prep_next.sdist  = sat_q(sd_full);
        prep_next.front  = !sd_full[NUMW-1] && (sd_full != '0);
        prep_next.inward = dot_reg.dd[DOTW-1];
    end

    always_comb begin
        mul_next.sx     = div_reg[QW].ray.start_x;
        mul_next.sy     = div_reg[QW].ray.start_y;
        mul_next.q      = div_reg[QW].q;
        mul_next.pass   = div_reg[QW].pass && (div_reg[QW].q <= div_reg[QW].ray.ray_length);
        mul_next.mx     = $signed({1'b0, div_reg[QW].q}) * div_reg[QW].ray.dir_x;
        mul_next.my     = $signed({1'b0, div_reg[QW].q}) * div_reg[QW].ray.dir_y;
        mul_next.sdist  = div_reg[QW].sdist;
        mul_next.front  = div_reg[QW].front;
        mul_next.inward = div_reg[QW].inward;
    end

    logic signed [NUMW-1:0] hx_full, hy_full;

    always_comb begin
        hx_full = {{(NUMW-DW){mul_reg.sx[DW-1]}}, mul_reg.sx}
                + {{(NUMW-FW){mul_reg.mx[PW-1]}}, mul_reg.mx[PW-1:QB]};
        hy_full = {{(NUMW-DW){mul_reg.sy[DW-1]}}, mul_reg.sy}
                + {{(NUMW-FW){mul_reg.my[PW-1]}}, mul_reg.my[PW-1:QB]};
        out_next.hit            = mul_reg.pass;
        out_next.hit_distance   = mul_reg.pass ? mul_reg.q : '0;
        out_next.hit_x          = mul_reg.pass ? sat_q(hx_full) : '0;
        out_next.hit_y          = mul_reg.pass ? sat_q(hy_full) : '0;
        out_next.start_distance = mul_reg.sdist;
        out_next.start_in_front = mul_reg.front;
        out_next.ray_inward     = mul_reg.inward;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_reg <= prod_next;
        end
        if (adv[1]) begin
            dot_reg <= dot_next;
        end
        if (adv[2]) begin
            div_reg[0] <= prep_next;
        end
        for (int j = 1; j <= QW; j++) begin
            if (adv[j+2]) begin
                div_reg[j] <= div_step(div_reg[j-1]);
            end
        end
        if (adv[QW+3]) begin
            mul_reg <= mul_next;
        end
        if (adv[QW+4]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.hit) |->
        (m_data.hit_distance == '0 && m_data.hit_x == '0 && m_data.hit_y == '0))
        else $error("miss result carries a nonzero hit field");

    a_front_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.start_in_front) |-> !m_data.start_distance[DW-1])
        else $error("start in front but distance negative");

    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v_reg[0] && !m_ready))
        else $error("input stalled with a free first stage or a draining output");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[QW+2] && div_reg[QW].pass) |-> (div_reg[QW].rem < div_reg[QW].dvs))
        else $error("divider remainder not below the divisor");
`endif

endmodule
`default_nettype wire
